FILE: sv/isst_pkg.sv
// Shared types and constants for the integer set span tracker.
// Used by the controller, the datapath and the top level; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package isst_pkg;

   localparam int DATA_W  = 32;
   localparam int COUNT_W = 9;
   localparam logic [COUNT_W-1:0] CAP_RESET = 9'd256;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_COMMIT,
      ST_REPLY
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic read;
      logic commit;
      logic respond;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic room;
      logic scan_left;
      logic pipe_busy;
   } stat_type;

endpackage
`default_nettype wire

FILE: sv/integer_set_span_tracker_unit.sv
// Integer set span tracker: n stored values, one value store read per cycle.
// Accepted item: the scan reads each stored value and takes the least gap, then the
// commit stores the value and the reply is issued. Rejected item (set full): reply only.
// busy stays high until the reply is issued; a new item is taken only while busy is low.
// Results are strobed for one cycle; the receiver cannot stall.
// Synchronous active-high reset: set empty, capacity 256, best gap all ones.
`timescale 1ns / 1ps
`default_nettype none
module integer_set_span_tracker_unit #(
   parameter int MAX_ENTRIES = 256
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   output logic                                     busy,
   input  wire logic signed [isst_pkg::DATA_W-1:0]  req_value_in,
   input  wire logic                                csr_wr_en,
   input  wire logic [isst_pkg::COUNT_W-1:0]        csr_wr_data,
   output logic                                     rsp_valid,
   output logic                                     rsp_accepted,
   output logic [isst_pkg::COUNT_W-1:0]             rsp_stored_count,
   output logic [isst_pkg::DATA_W-1:0]              rsp_shortest_gap,
   output logic [isst_pkg::DATA_W-1:0]              rsp_widest_gap,
   output logic                                     rsp_spans_valid
);

   isst_pkg::cmd_type  cmd;
   isst_pkg::stat_type stat;

   isst_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .stat  (stat),
      .cmd   (cmd),
      .busy  (busy)
   );

   isst_dpath #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .value_in         (req_value_in),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .rsp_valid        (rsp_valid),
      .rsp_accepted     (rsp_accepted),
      .rsp_stored_count (rsp_stored_count),
      .rsp_shortest_gap (rsp_shortest_gap),
      .rsp_widest_gap   (rsp_widest_gap),
      .rsp_spans_valid  (rsp_spans_valid)
   );

`ifndef SYNTHESIS
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result without an item in flight");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted item did not raise busy");

   a_accept_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_accepted |-> rsp_stored_count != '0)
      else $error("stored item reported with empty set");

   a_spans_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_spans_valid |-> rsp_shortest_gap == '0 && rsp_widest_gap == '0)
      else $error("spans reported while fewer than two values held");
`endif

endmodule
`default_nettype wire

FILE: sv/isst_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module isst_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

FILE: sv/isst_ctrl.sv
// Controller for the span tracker: sequences accept, scan, commit and reply.
// Depends on isst_pkg.
`timescale 1ns / 1ps
`default_nettype none
module isst_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire isst_pkg::stat_type stat,
   output isst_pkg::cmd_type      cmd,
   output logic                   busy
);

   isst_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= isst_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         isst_pkg::ST_IDLE: begin
            if (start) begin
               state_in = stat.room ? isst_pkg::ST_SCAN : isst_pkg::ST_REPLY;
            end
         end
         isst_pkg::ST_SCAN: begin
            if (!stat.scan_left && !stat.pipe_busy) begin
               state_in = isst_pkg::ST_COMMIT;
            end
         end
         isst_pkg::ST_COMMIT: state_in = isst_pkg::ST_REPLY;
         isst_pkg::ST_REPLY:  state_in = isst_pkg::ST_IDLE;
         default:             state_in = isst_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd  = '0;
      busy = 1'b1;
      unique case (state_ff)
         isst_pkg::ST_IDLE: begin
            busy     = 1'b0;
            cmd.load = start;
         end
         isst_pkg::ST_SCAN:   cmd.read    = stat.scan_left;
         isst_pkg::ST_COMMIT: cmd.commit  = 1'b1;
         isst_pkg::ST_REPLY:  cmd.respond = 1'b1;
         default:             busy        = 1'b1;
      endcase
   end

endmodule
`default_nettype wire

FILE: sv/isst_dpath.sv
// Datapath for the span tracker: value store, gap scan pipeline, running
// min/max/best gap, capacity register and registered result.
// Depends on isst_pkg and isst_ram.
`timescale 1ns / 1ps
`default_nettype none
module isst_dpath #(
   parameter int MAX_ENTRIES = 256
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire isst_pkg::cmd_type                   cmd,
   output isst_pkg::stat_type                       stat,
   input  wire logic signed [isst_pkg::DATA_W-1:0]  value_in,
   input  wire logic                                csr_wr_en,
   input  wire logic [isst_pkg::COUNT_W-1:0]        csr_wr_data,
   output logic                                     rsp_valid,
   output logic                                     rsp_accepted,
   output logic [isst_pkg::COUNT_W-1:0]             rsp_stored_count,
   output logic [isst_pkg::DATA_W-1:0]              rsp_shortest_gap,
   output logic [isst_pkg::DATA_W-1:0]              rsp_widest_gap,
   output logic                                     rsp_spans_valid
);

   localparam int AW = $clog2(MAX_ENTRIES);
   localparam int DW = isst_pkg::DATA_W;
   localparam int CW = isst_pkg::COUNT_W;

   logic [CW-1:0]        cap_ff;
   logic [CW-1:0]        fill_ff;
   logic [CW-1:0]        idx_ff;
   logic signed [DW-1:0] value_ff;
   logic signed [DW-1:0] least_ff;
   logic signed [DW-1:0] greatest_ff;
   logic [DW-1:0]        best_ff;
   logic                 acc_ff;
   logic                 rd_vld_ff;
   logic                 gap_vld_ff;
   logic [DW-1:0]        gap_ff, gap_in;

   logic                 rsp_valid_ff;
   logic                 rsp_accepted_ff;
   logic [CW-1:0]        rsp_count_ff;
   logic [DW-1:0]        rsp_short_ff;
   logic [DW-1:0]        rsp_wide_ff;
   logic                 rsp_spans_ff;

   logic [CW-1:0]        limit;
   logic [DW-1:0]        rd_data;
   logic signed [DW:0]   diff;
   logic                 two_or_more;

   always_comb begin
      if ({{(32-CW){1'b0}}, cap_ff} > 32'(MAX_ENTRIES)) begin
         limit = CW'(MAX_ENTRIES);
      end else begin
         limit = cap_ff;
      end
   end

   assign stat.room      = fill_ff < limit;
   assign stat.scan_left = idx_ff != fill_ff;
   assign stat.pipe_busy = rd_vld_ff | gap_vld_ff;

   isst_ram #(
      .WIDTH (DW),
      .DEPTH (MAX_ENTRIES)
   ) u_store (
      .clock   (clock),
      .wr_en   (cmd.commit),
      .wr_addr (AW'(fill_ff)),
      .wr_data (value_ff),
      .rd_en   (cmd.read),
      .rd_addr (AW'(idx_ff)),
      .rd_data (rd_data)
   );

   // gap stage: |value - stored|, fits in 32 bits unsigned
   always_comb begin
      diff   = {value_ff[DW-1], value_ff} - {rd_data[DW-1], rd_data};
      gap_in = diff[DW] ? DW'(-diff) : diff[DW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff  <= 1'b0;
         gap_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff  <= cmd.read;
         gap_vld_ff <= rd_vld_ff;
      end
      if (rd_vld_ff) begin
         gap_ff <= gap_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff      <= isst_pkg::CAP_RESET;
         fill_ff     <= '0;
         least_ff    <= '0;
         greatest_ff <= '0;
         best_ff     <= '1;
         idx_ff      <= '0;
         acc_ff      <= 1'b0;
      end else if (csr_wr_en) begin
         cap_ff      <= csr_wr_data;
         fill_ff     <= '0;
         least_ff    <= '0;
         greatest_ff <= '0;
         best_ff     <= '1;
      end else begin
         if (cmd.load) begin
            idx_ff <= '0;
            acc_ff <= 1'b0;
         end else if (cmd.read) begin
            idx_ff <= idx_ff + 1'b1;
         end
         if (gap_vld_ff && (gap_ff < best_ff)) begin
            best_ff <= gap_ff;
         end
         if (cmd.commit) begin
            fill_ff <= fill_ff + 1'b1;
            acc_ff  <= 1'b1;
            if (fill_ff == '0) begin
               least_ff    <= value_ff;
               greatest_ff <= value_ff;
            end else begin
               if (value_ff < least_ff) begin
                  least_ff <= value_ff;
               end
               if (value_ff > greatest_ff) begin
                  greatest_ff <= value_ff;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         value_ff <= value_in;
      end
   end

   assign two_or_more = fill_ff >= CW'(2);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.respond;
      end
      if (cmd.respond) begin
         rsp_accepted_ff <= acc_ff;
         rsp_count_ff    <= fill_ff;
         rsp_spans_ff    <= two_or_more;
         rsp_short_ff    <= two_or_more ? best_ff : '0;
         rsp_wide_ff     <= two_or_more ? (greatest_ff - least_ff) : '0;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_accepted     = rsp_accepted_ff;
   assign rsp_stored_count = rsp_count_ff;
   assign rsp_shortest_gap = rsp_short_ff;
   assign rsp_widest_gap   = rsp_wide_ff;
   assign rsp_spans_valid  = rsp_spans_ff;

endmodule
`default_nettype wire

FILE: bench/tb.sv
// Self-checking bench for integer_set_span_tracker_unit: directed table, then random phases
// at several capacities and sender idle rates, checked against an in-bench set predictor.
// Depends on sv/isst_pkg.sv and sv/integer_set_span_tracker_unit.sv.
`timescale 1ns / 1ps
module tb;

   localparam int MAX_ENTRIES = 256;
   localparam int ITEM_TARGET = 1050;
   localparam int IDLE_MODES [3] = '{0, 71, 26};

   typedef struct packed {
      logic                          accepted;
      logic [isst_pkg::COUNT_W-1:0]  count;
      logic [isst_pkg::DATA_W-1:0]   shortest;
      logic [isst_pkg::DATA_W-1:0]   widest;
      logic                          valid;
   } span_result_type;

   typedef enum logic {ROW_ITEM, ROW_CAP} row_kind_type;

   typedef struct packed {
      row_kind_type                  kind;
      logic [isst_pkg::COUNT_W-1:0]  cap;
      logic [isst_pkg::DATA_W-1:0]   value;
      logic                          typed;
      span_result_type               want;
   } dir_row_type;

   localparam int DIR_ROWS = 21;
   dir_row_type directed_rows [DIR_ROWS] = '{
      '{ROW_ITEM, 9'd0,   32'h8000_0000, 1'b1, '{1'b1, 9'd1, 32'd0, 32'd0, 1'b0}},
      '{ROW_ITEM, 9'd0,   32'h7FFF_FFFF, 1'b1,
         '{1'b1, 9'd2, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1}},
      '{ROW_ITEM, 9'd0,   32'h7FFF_FFFF, 1'b1, '{1'b1, 9'd3, 32'd0, 32'hFFFF_FFFF, 1'b1}},
      '{ROW_ITEM, 9'd0,   32'hFFFF_FFFF, 1'b0, '0},
      '{ROW_ITEM, 9'd0,   32'h0000_0000, 1'b0, '0},
      '{ROW_CAP,  9'd0,   32'd0,         1'b0, '0},
      '{ROW_ITEM, 9'd0,   32'd5,         1'b1, '{1'b0, 9'd0, 32'd0, 32'd0, 1'b0}},
      '{ROW_ITEM, 9'd0,   32'h8000_0000, 1'b1, '{1'b0, 9'd0, 32'd0, 32'd0, 1'b0}},
      '{ROW_CAP,  9'd1,   32'd0,         1'b0, '0},
      '{ROW_ITEM, 9'd0,   32'hFFFF_FFFF, 1'b1, '{1'b1, 9'd1, 32'd0, 32'd0, 1'b0}},
      '{ROW_ITEM, 9'd0,   32'd0,         1'b1, '{1'b0, 9'd1, 32'd0, 32'd0, 1'b0}},
      '{ROW_CAP,  9'd2,   32'd0,         1'b0, '0},
      '{ROW_ITEM, 9'd0,   32'd100,       1'b1, '{1'b1, 9'd1, 32'd0, 32'd0, 1'b0}},
      '{ROW_ITEM, 9'd0,   32'hFFFF_FF9C, 1'b1, '{1'b1, 9'd2, 32'd200, 32'd200, 1'b1}},
      '{ROW_ITEM, 9'd0,   32'd7,         1'b1, '{1'b0, 9'd2, 32'd200, 32'd200, 1'b1}},
      '{ROW_CAP,  9'd511, 32'd0,         1'b0, '0},
      '{ROW_ITEM, 9'd0,   32'd0,         1'b0, '0},
      '{ROW_ITEM, 9'd0,   32'd0,         1'b1, '{1'b1, 9'd2, 32'd0, 32'd0, 1'b1}},
      '{ROW_ITEM, 9'd0,   32'd3,         1'b0, '0},
      '{ROW_ITEM, 9'd0,   32'hFFFF_FFFE, 1'b0, '0},
      '{ROW_CAP,  9'd256, 32'd0,         1'b0, '0}
   };

   logic                                clock;
   logic                                reset;
   logic                                start;
   logic                                busy;
   logic signed [isst_pkg::DATA_W-1:0]  req_value_in;
   logic                                csr_wr_en;
   logic [isst_pkg::COUNT_W-1:0]        csr_wr_data;
   logic                                rsp_valid;
   logic                                rsp_accepted;
   logic [isst_pkg::COUNT_W-1:0]        rsp_stored_count;
   logic [isst_pkg::DATA_W-1:0]         rsp_shortest_gap;
   logic [isst_pkg::DATA_W-1:0]         rsp_widest_gap;
   logic                                rsp_spans_valid;

   // predictor state
   logic [isst_pkg::DATA_W-1:0]   held_values [MAX_ENTRIES];
   logic [isst_pkg::COUNT_W-1:0]  held_count;
   logic [isst_pkg::DATA_W-1:0]   least_held;
   logic [isst_pkg::DATA_W-1:0]   greatest_held;
   logic [isst_pkg::DATA_W-1:0]   tightest_gap;
   logic [isst_pkg::COUNT_W-1:0]  cap_limit;

   span_result_type  pending_spans [$];
   int               error_count;
   int               items_sent;
   int               idle_pct;

   integer_set_span_tracker_unit #(.MAX_ENTRIES(MAX_ENTRIES)) u_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_value_in     (req_value_in),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .rsp_valid        (rsp_valid),
      .rsp_accepted     (rsp_accepted),
      .rsp_stored_count (rsp_stored_count),
      .rsp_shortest_gap (rsp_shortest_gap),
      .rsp_widest_gap   (rsp_widest_gap),
      .rsp_spans_valid  (rsp_spans_valid)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   function automatic logic [isst_pkg::DATA_W-1:0] span_of(
      logic [isst_pkg::DATA_W-1:0] a,
      logic [isst_pkg::DATA_W-1:0] b
   );
      longint diff;
      diff = longint'($signed(a)) - longint'($signed(b));
      if (diff < 0) diff = -diff;
      return diff[isst_pkg::DATA_W-1:0];
   endfunction

   function automatic void empty_set();
      held_count    = '0;
      least_held    = '0;
      greatest_held = '0;
      tightest_gap  = '1;
   endfunction

   function automatic span_result_type track_value(logic [isst_pkg::DATA_W-1:0] v);
      span_result_type  res;
      int               room;
      int               i;
      room = (cap_limit > MAX_ENTRIES) ? MAX_ENTRIES : int'(cap_limit);
      res = '0;
      if (held_count < room) begin
         for (i = 0; i < held_count; i++) begin
            if (span_of(v, held_values[i]) < tightest_gap) begin
               tightest_gap = span_of(v, held_values[i]);
            end
         end
         if (held_count == 0) begin
            least_held    = v;
            greatest_held = v;
         end else begin
            if ($signed(v) < $signed(least_held)) least_held = v;
            if ($signed(v) > $signed(greatest_held)) greatest_held = v;
         end
         held_values[held_count] = v;
         held_count++;
         res.accepted = 1'b1;
      end
      res.count = held_count;
      if (held_count >= 2) begin
         res.shortest = tightest_gap;
         res.widest   = span_of(greatest_held, least_held);
         res.valid    = 1'b1;
      end
      return res;
   endfunction

   // about two in five values near or equal to stored ones, so small gaps and duplicates are frequent
   function automatic logic [isst_pkg::DATA_W-1:0] pick_value();
      int                           r;
      logic [isst_pkg::DATA_W-1:0]  base;
      r = $urandom_range(0, 99);
      base = (held_count != 0) ? held_values[$urandom_range(0, held_count - 1)] : $urandom();
      if (r < 8) begin
         case ($urandom_range(0, 4))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0000_0000;
            3: return 32'hFFFF_FFFF;
            default: return 32'h0000_0001;
         endcase
      end else if (r < 20) begin
         return base;
      end else if (r < 50) begin
         return base + $urandom_range(0, 16) - 8;
      end
      return $urandom();
   endfunction

   task automatic write_capacity(logic [isst_pkg::COUNT_W-1:0] cap);
      while (pending_spans.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      while (busy) @(negedge clock);
      csr_wr_en   = 1'b1;
      csr_wr_data = cap;
      @(negedge clock);
      csr_wr_en = 1'b0;
      cap_limit = cap;
      empty_set();
   endtask

   task automatic send_item(logic [isst_pkg::DATA_W-1:0] v, logic typed,
                            span_result_type want);
      span_result_type predicted;
      if (idle_pct > 0) begin
         while ($urandom_range(0, 99) < idle_pct) @(negedge clock);
      end
      start        = 1'b1;
      req_value_in = v;
      do @(posedge clock); while (busy);
      predicted = track_value(v);
      if (typed) predicted = want;
      pending_spans = {pending_spans, predicted};
      items_sent++;
      @(negedge clock);
      start = 1'b0;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (pending_spans.size() == 0) begin
            $error("result with nothing expected");
            error_count++;
         end else begin
            span_result_type exp_r;
            exp_r = pending_spans.pop_front();
            if (rsp_accepted !== exp_r.accepted) begin
               $error("accepted: expected %0d, got %0d", exp_r.accepted, rsp_accepted);
               error_count++;
            end
            if (rsp_stored_count !== exp_r.count) begin
               $error("stored_count: expected %0d, got %0d", exp_r.count, rsp_stored_count);
               error_count++;
            end
            if (rsp_shortest_gap !== exp_r.shortest) begin
               $error("shortest_gap: expected %0h, got %0h", exp_r.shortest, rsp_shortest_gap);
               error_count++;
            end
            if (rsp_widest_gap !== exp_r.widest) begin
               $error("widest_gap: expected %0h, got %0h", exp_r.widest, rsp_widest_gap);
               error_count++;
            end
            if (rsp_spans_valid !== exp_r.valid) begin
               $error("spans_valid: expected %0d, got %0d", exp_r.valid, rsp_spans_valid);
               error_count++;
            end
         end
      end
   end

   initial begin
      int phase;
      int n_items;
      int cap;
      int k;
      reset        = 1'b1;
      start        = 1'b0;
      req_value_in = '0;
      csr_wr_en    = 1'b0;
      csr_wr_data  = '0;
      error_count  = 0;
      items_sent   = 0;
      idle_pct     = 0;
      cap_limit    = isst_pkg::CAP_RESET;
      empty_set();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (k = 0; k < DIR_ROWS; k++) begin
         if (directed_rows[k].kind == ROW_CAP) write_capacity(directed_rows[k].cap);
         else send_item(directed_rows[k].value, directed_rows[k].typed, directed_rows[k].want);
      end

      items_sent = 0;
      phase = 0;
      while (items_sent < ITEM_TARGET) begin
         idle_pct = IDLE_MODES[phase % 3];
         if (phase == 2) begin
            cap = 511;
            n_items = MAX_ENTRIES + 6;
         end else if (phase == 6) begin
            cap = 256;
            n_items = MAX_ENTRIES + 2;
         end else if ($urandom_range(0, 9) == 0) begin
            cap = $urandom_range(0, 511);
            n_items = $urandom_range(1, 40);
         end else begin
            cap = $urandom_range(0, 30);
            n_items = $urandom_range(cap / 2 + 1, cap + 6);
         end
         write_capacity(cap[isst_pkg::COUNT_W-1:0]);
         repeat (n_items) send_item(pick_value(), 1'b0, '0);
         phase++;
      end

      while (pending_spans.size() != 0) @(negedge clock);
      repeat (300) @(negedge clock);
      if (error_count == 0 && pending_spans.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
